// File: hw/rtl/lsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_pkg
// Shared types and constants for the LED strip frame encoder.
// ----------------------------------------------------------------------------
package lsfe_pkg;

  localparam int PIXELS         = 16;
  localparam int PIX_AW         = $clog2(PIXELS);
  localparam int BITS_PER_PIXEL = 24;
  localparam int BYTES_PER_WORD = 8;
  localparam int WORDS_PER_PIX  = BITS_PER_PIXEL / BYTES_PER_WORD;
  localparam int PART_W         = $clog2(WORDS_PER_PIX);
  localparam int CFG_AW         = 3;

  localparam logic [7:0] ONE_PATTERN_RST  = 8'd248;
  localparam logic [7:0] ZERO_PATTERN_RST = 8'd192;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_WRITE_SHOW = 2'd1,
    OP_CLEAR_SHOW = 2'd2,
    OP_SHOW       = 2'd3
  } op_t;

  typedef enum logic {
    REG_ONE_PATTERN  = 1'b0,
    REG_ZERO_PATTERN = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  pixel_index;
    logic [23:0] color;
  } in_word_t;

  typedef struct packed {
    logic [63:0] spi_bytes;
    logic        last_word;
  } out_word_t;

  // Request from the sequencer to the frame store.
  typedef struct packed {
    logic              wr_en;
    logic [PIX_AW-1:0] wr_addr;
    logic [23:0]       wr_color;
    logic              clr_all;
    logic              rd_en;
    logic [PIX_AW-1:0] rd_addr;
  } store_req_t;

  // Registered read result of the frame store.
  typedef struct packed {
    logic [23:0] color;
    logic        written;
    logic        cleared;
  } store_rsp_t;

endpackage

// File: hw/rtl/lsfe_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_frame_store
// Pixel color memory with one write and one read port and a registered read result,
// plus per-pixel written and cleared flags.
// ----------------------------------------------------------------------------
module lsfe_frame_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsfe_pkg::store_req_t  req,
  output lsfe_pkg::store_rsp_t  rsp
);

  logic [23:0]               mem [lsfe_pkg::PIXELS];
  logic [lsfe_pkg::PIXELS-1:0] written_r, written_nxt;
  logic [lsfe_pkg::PIXELS-1:0] cleared_r, cleared_nxt;
  logic [23:0]               rd_color_r;
  logic                      rd_written_r;
  logic                      rd_cleared_r;

  // A clear marks every entry as reading zero, so the memory itself is never swept.
  always_comb begin
    written_nxt = written_r;
    cleared_nxt = cleared_r;
    if (req.clr_all) begin
      written_nxt = '1;
      cleared_nxt = '1;
    end else if (req.wr_en) begin
      written_nxt[req.wr_addr] = 1'b1;
      cleared_nxt[req.wr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      cleared_r <= '0;
    end else begin
      written_r <= written_nxt;
      cleared_r <= cleared_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_color;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_color_r   <= mem[req.rd_addr];
      rd_written_r <= written_r[req.rd_addr];
      rd_cleared_r <= cleared_r[req.rd_addr];
    end
  end

  assign rsp.color   = rd_color_r;
  assign rsp.written = rd_written_r;
  assign rsp.cleared = rd_cleared_r;

endmodule

// File: hw/rtl/led_strip_frame_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_frame_encoder_core
// Frame store of GRB pixels streamed out as SPI bit-expansion bytes.
// ----------------------------------------------------------------------------
// A write-only word is written to the frame store; the next word is accepted the cycle after.
// A show word passes the read state, which reads the first pixel, then the emit state:
// one result word per cycle unless out_stall holds it (48 words), paced by one
// frame-store read per three words. A new input word is taken once the last show
// word is in the output register. Reset clears all pixel flags at once (no clearing
// pass) and loads the default one and zero patterns.
module led_strip_frame_encoder_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lsfe_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lsfe_pkg::out_word_t   out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [lsfe_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  lsfe_pkg::state_t            state_r, state_nxt;
  logic [lsfe_pkg::PIX_AW-1:0] pix_r, pix_nxt;
  logic [lsfe_pkg::PART_W-1:0] part_r, part_nxt;
  logic [7:0]                  one_pat_r, zero_pat_r;
  logic                        out_valid_r, out_valid_nxt;
  lsfe_pkg::out_word_t         out_data_r, out_data_nxt;
  lsfe_pkg::store_req_t        req;
  lsfe_pkg::store_rsp_t        rsp;
  logic                        in_fire;
  logic                        out_free;
  logic                        cfg_wr;
  logic                        idx_ok;
  logic                        last_pix;
  logic [23:0]                 pix_color;
  logic [7:0]                  slice;
  logic [63:0]                 enc;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_pat_r  <= lsfe_pkg::ONE_PATTERN_RST;
      zero_pat_r <= lsfe_pkg::ZERO_PATTERN_RST;
    end else if (cfg_wr) begin
      case (lsfe_pkg::reg_idx_t'(cfg_paddr[2]))
        lsfe_pkg::REG_ONE_PATTERN:  one_pat_r  <= cfg_pwdata[7:0];
        lsfe_pkg::REG_ZERO_PATTERN: zero_pat_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lsfe_pkg::reg_idx_t'(cfg_paddr[2]))
      lsfe_pkg::REG_ONE_PATTERN:  cfg_prdata = {24'd0, one_pat_r};
      lsfe_pkg::REG_ZERO_PATTERN: cfg_prdata = {24'd0, zero_pat_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // Frame store.
  lsfe_frame_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_stall = (state_r != lsfe_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_ok   = (in_data.pixel_index < 8'(lsfe_pkg::PIXELS));
  assign last_pix = (pix_r == lsfe_pkg::PIX_AW'(lsfe_pkg::PIXELS - 1));

  // Encode the current third of the pixel held in the read register.
  assign pix_color = rsp.cleared ? 24'd0 : rsp.color;

  always_comb begin
    case (part_r)
      2'd0:    slice = pix_color[23:16];
      2'd1:    slice = pix_color[15:8];
      default: slice = pix_color[7:0];
    endcase
    for (int k = 0; k < lsfe_pkg::BYTES_PER_WORD; k++) begin
      if (!rsp.written) begin
        enc[63-8*k -: 8] = 8'd0;
      end else if (slice[7-k]) begin
        enc[63-8*k -: 8] = one_pat_r;
      end else begin
        enc[63-8*k -: 8] = zero_pat_r;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pix_nxt       = pix_r;
    part_nxt      = part_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    req.wr_en    = 1'b0;
    req.wr_addr  = in_data.pixel_index[lsfe_pkg::PIX_AW-1:0];
    req.wr_color = in_data.color;
    req.clr_all  = 1'b0;
    req.rd_en    = 1'b0;
    req.rd_addr  = pix_r;

    case (state_r)
      lsfe_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (lsfe_pkg::op_t'(in_data.operation))
            lsfe_pkg::OP_WRITE: begin
              req.wr_en = idx_ok;
            end
            lsfe_pkg::OP_WRITE_SHOW: begin
              req.wr_en = idx_ok;
              state_nxt = lsfe_pkg::ST_READ;
            end
            lsfe_pkg::OP_CLEAR_SHOW: begin
              req.clr_all = 1'b1;
              state_nxt   = lsfe_pkg::ST_READ;
            end
            lsfe_pkg::OP_SHOW: begin
              state_nxt = lsfe_pkg::ST_READ;
            end
            default: ;
          endcase
          pix_nxt  = '0;
          part_nxt = '0;
        end
      end
      lsfe_pkg::ST_READ: begin
        req.rd_en = 1'b1;
        state_nxt = lsfe_pkg::ST_EMIT;
      end
      lsfe_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.spi_bytes = enc;
          out_data_nxt.last_word = 1'b0;
          if (part_r == lsfe_pkg::PART_W'(lsfe_pkg::WORDS_PER_PIX - 1)) begin
            part_nxt = '0;
            if (last_pix) begin
              out_data_nxt.last_word = 1'b1;
              state_nxt              = lsfe_pkg::ST_IDLE;
            end else begin
              // Fetch the next pixel while its predecessor's last word goes out.
              pix_nxt     = pix_r + 1'b1;
              req.rd_en   = 1'b1;
              req.rd_addr = pix_r + 1'b1;
            end
          end else begin
            part_nxt = part_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = lsfe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsfe_pkg::ST_IDLE;
      pix_r       <= '0;
      part_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pix_r       <= pix_nxt;
      part_r      <= part_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
